FILE: sv/ahfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ahfr_pkg;

   localparam int MAX_FRAME_CHARS = 512;
   localparam int POS_W = 10;
   localparam int LEN_W = 12;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] END_BYTE = 8'h0D;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_CHARS - 2);
   localparam logic [POS_W-1:0] HDR_CHARS = POS_W'(8);
   localparam int HEAD_CHARS = 12;
   localparam logic [LEN_W:0] HEAD_END = (LEN_W + 1)'(HEAD_CHARS);
   localparam logic [LEN_W:0] FRAME_END = (LEN_W + 1)'(HEAD_CHARS + 4);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_LEN_BAD = 3'd1;
   localparam logic [2:0] ST_SUM_BAD = 3'd2;
   localparam logic [2:0] ST_END_POS = 3'd3;
   localparam logic [2:0] ST_NON_HEX = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nib = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.nib = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.nib = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
         h.nib = 4'd0;
      end
      return h;
   endfunction

endpackage
`default_nettype wire

FILE: sv/ascii_hex_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                                    | direction
// request  | req_valid, req_ready, req_rx_byte        | in
// response | rsp_valid, rsp_ready, rsp_info_byte,     | out
//          | rsp_is_status, rsp_status, rsp_version,  |
//          | rsp_address, rsp_cid_one, rsp_cid_two,   |
//          | rsp_info_length                          |
// one character per cycle: frame state updates in the accepting cycle and
// any response lands in the output register, visible the next cycle
// req_ready is low only while a response is held and rsp_ready is low
// reset (synchronous) returns to hunting for the start byte

module ascii_hex_frame_receiver (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_rx_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_info_byte,
   output logic                           rsp_is_status,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_version,
   output logic [7:0]                     rsp_address,
   output logic [7:0]                     rsp_cid_one,
   output logic [7:0]                     rsp_cid_two,
   output logic [ahfr_pkg::LEN_W-1:0]     rsp_info_length
);
   import ahfr_pkg::*;

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       high_nib_ff, high_nib_in;
   logic [7:0]       hdr_ff [4];
   logic [7:0]       hdr_in [4];
   logic [15:0]      length_ff, length_in;
   logic [15:0]      run_sum_ff, run_sum_in;
   logic [15:0]      rcv_sum_ff, rcv_sum_in;
   logic             bad_hex_ff, bad_hex_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       info_ff, info_in;
   logic             is_stat_ff, is_stat_in;
   logic [2:0]       stat_ff, stat_in;
   logic [7:0]       out_hdr_ff [4];
   logic [7:0]       out_hdr_in [4];
   logic [LEN_W-1:0] out_len_ff, out_len_in;

   logic             accept;
   logic             emit;
   hex_type          hx;
   logic [LEN_W-1:0] lenid;
   logic [LEN_W:0]   pos_ext;
   logic [5:0]       lsum;
   logic [3:0]       lchk;
   logic [15:0]      csum;
   logic [15:0]      sum_add;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign hx = hex_decode(req_rx_byte);
   assign lenid = length_ff[LEN_W-1:0];
   assign pos_ext = {3'b000, pos_ff};
   assign lsum = 6'(lenid[3:0]) + 6'(lenid[7:4]) + 6'(lenid[11:8]);
   assign lchk = 4'(6'd0 - lsum);
   assign csum = 16'd0 - run_sum_ff;
   assign sum_add = run_sum_ff + {8'd0, req_rx_byte};

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in = pos_ff;
      high_nib_in = high_nib_ff;
      hdr_in = hdr_ff;
      length_in = length_ff;
      run_sum_in = run_sum_ff;
      rcv_sum_in = rcv_sum_ff;
      bad_hex_in = bad_hex_ff;
      emit = 1'b0;
      info_in = 8'd0;
      is_stat_in = 1'b0;
      stat_in = ST_OK;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == START_BYTE) begin
               in_frame_in = 1'b1;
               pos_in = '0;
               high_nib_in = 4'd0;
               for (int i = 0; i < 4; i++) hdr_in[i] = 8'd0;
               length_in = 16'd0;
               run_sum_in = 16'd0;
               rcv_sum_in = 16'd0;
               bad_hex_in = 1'b0;
            end
         end else if (req_rx_byte == END_BYTE) begin
            emit = 1'b1;
            is_stat_in = 1'b1;
            in_frame_in = 1'b0;
            priority if (pos_ext != FRAME_END + {1'b0, lenid}) begin
               stat_in = ST_END_POS;
            end else if (bad_hex_ff) begin
               stat_in = ST_NON_HEX;
            end else if (lchk != length_ff[15:12]) begin
               stat_in = ST_LEN_BAD;
            end else if (csum != rcv_sum_ff) begin
               stat_in = ST_SUM_BAD;
            end else begin
               stat_in = ST_OK;
            end
         end else if (pos_ff >= POS_LIMIT) begin
            emit = 1'b1;
            is_stat_in = 1'b1;
            stat_in = ST_OVERFLOW;
            in_frame_in = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            priority if (pos_ff < HDR_CHARS) begin
               run_sum_in = sum_add;
               bad_hex_in = bad_hex_ff || !hx.ok;
               if (!pos_ff[0]) begin
                  high_nib_in = hx.nib;
               end else begin
                  hdr_in[pos_ff[2:1]] = {high_nib_ff, hx.nib};
               end
            end else if (pos_ext < HEAD_END) begin
               run_sum_in = sum_add;
               bad_hex_in = bad_hex_ff || !hx.ok;
               length_in = {length_ff[11:0], hx.nib};
            end else if (pos_ext < HEAD_END + {1'b0, lenid}) begin
               run_sum_in = sum_add;
               bad_hex_in = bad_hex_ff || !hx.ok;
               if (!pos_ff[0]) begin
                  high_nib_in = hx.nib;
               end else begin
                  emit = 1'b1;
                  info_in = {high_nib_ff, hx.nib};
               end
            end else if (pos_ext < FRAME_END + {1'b0, lenid}) begin
               bad_hex_in = bad_hex_ff || !hx.ok;
               rcv_sum_in = {rcv_sum_ff[11:0], hx.nib};
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_hdr_in = out_hdr_ff;
      out_len_in = out_len_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_hdr_in = hdr_ff;
         out_len_in = lenid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff <= '0;
         high_nib_ff <= 4'd0;
         for (int i = 0; i < 4; i++) hdr_ff[i] <= 8'd0;
         length_ff <= 16'd0;
         run_sum_ff <= 16'd0;
         rcv_sum_ff <= 16'd0;
         bad_hex_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff <= pos_in;
         high_nib_ff <= high_nib_in;
         hdr_ff <= hdr_in;
         length_ff <= length_in;
         run_sum_ff <= run_sum_in;
         rcv_sum_ff <= rcv_sum_in;
         bad_hex_ff <= bad_hex_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         info_ff <= info_in;
         is_stat_ff <= is_stat_in;
         stat_ff <= stat_in;
      end
      out_hdr_ff <= out_hdr_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_info_byte = info_ff;
   assign rsp_is_status = is_stat_ff;
   assign rsp_status = stat_ff;
   assign rsp_version = out_hdr_ff[0];
   assign rsp_address = out_hdr_ff[1];
   assign rsp_cid_one = out_hdr_ff[2];
   assign rsp_cid_two = out_hdr_ff[3];
   assign rsp_info_length = out_len_ff;

   // status responses carry no info byte, info responses carry ok status
   a_stat_info: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_status |-> rsp_info_byte == 8'd0)
      else $error("status response with nonzero info byte");

   a_info_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |-> rsp_status == ST_OK)
      else $error("info response with nonzero status");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("character position past frame limit");

   a_frame_exit: assert property (@(posedge clock) disable iff (reset)
      accept && in_frame_ff && rsp_valid_in && is_stat_in |=> !in_frame_ff)
      else $error("status response without leaving frame");

endmodule
`default_nettype wire
